### rtl/core/assert_macros.svh
// Assertion macros for the checker file of the motion detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SDMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SDMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sdmd_pkg.sv
// Shared constants, types and helper functions of the sigma-delta motion detector.
package sdmd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int W_DIM_W = $clog2(MAX_WIDTH + 1);
  localparam int H_DIM_W = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W      = 8;
  localparam int CFG_SIZE_W = 11;
  localparam int GAIN_W     = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int TGT_W      = PIX_W + GAIN_W;
  localparam int VAR_EXT_W  = PIX_W + 1;

  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [GAIN_W-1:0]     RST_GAIN         = 4'd3;

  localparam logic [PIX_W-1:0] VAR_MIN = 8'd1;
  localparam logic [PIX_W-1:0] VAR_MAX = 8'd255;
  localparam logic [PIX_W-1:0] BG_CLEAR = 8'd0;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_VARIANCE_GAIN = 2'd2
  } cfg_reg_t;

  // One store word: background estimate over variance estimate.
  typedef struct packed {
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] var_est;
  } model_word_t;

  localparam model_word_t CLEAR_WORD = '{bg: BG_CLEAR, var_est: VAR_MIN};

  // A classified pixel on its way from the front to the back.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              eof;
  } job_t;

  function automatic logic [W_DIM_W-1:0] limit_width(logic [CFG_SIZE_W-1:0] v);
    logic [W_DIM_W-1:0] r;
    if (v == '0) r = W_DIM_W'(1);
    else if (int'(v) > MAX_WIDTH) r = W_DIM_W'(MAX_WIDTH);
    else r = W_DIM_W'(v);
    return r;
  endfunction

  function automatic logic [H_DIM_W-1:0] limit_height(logic [CFG_SIZE_W-1:0] v);
    logic [H_DIM_W-1:0] r;
    if (v == '0) r = H_DIM_W'(1);
    else if (int'(v) > MAX_HEIGHT) r = H_DIM_W'(MAX_HEIGHT);
    else r = H_DIM_W'(v);
    return r;
  endfunction

endpackage

### rtl/core/sdmd_if.sv
// Valid/ready stream interfaces for pixels in and detection results out.
interface sdmd_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sdmd_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sdmd_res_if;
  logic                      valid;
  logic                      ready;
  logic                      motion;
  logic [sdmd_pkg::PIX_W-1:0] abs_difference;
  logic                      end_of_frame;

  modport source (output valid, output motion, output abs_difference,
                  output end_of_frame, input ready);
  modport sink   (input valid, input motion, input abs_difference,
                  input end_of_frame, output ready);
endinterface

### rtl/core/sigma_delta_motion_detect.sv
// Top level of the sigma-delta motion detector: config registers and front/queue/back.
//
// Sigma-delta background subtraction on a greyscale raster stream. Every pixel
// position keeps a background estimate (steps by one toward the pixel) and a
// variance estimate (steps by one toward gain times the difference, held in
// 1..255); a pixel is flagged as motion when its difference is not below the
// updated variance. Rate: one pixel per clock while the result side keeps up,
// one result per pixel, in order; a result passes the queue, the store read
// stage and the result register before it is presented. The rate is set by the
// model store, which does one read and one write of a {background, variance}
// word per clock; a two-entry queue separates the position tracking from the
// store pipeline so either side may stall. After reset the store is swept to
// background 0 / variance 1, one word per clock, through all 1,048,576 words
// (MAX_WIDTH * MAX_HEIGHT); in_px.ready stays low until the sweep is done, while
// configuration writes are taken as usual. Write frame_width, frame_height and
// variance_gain only while idle; they act on the next pixel and leave the
// stored model and position alone.
module sigma_delta_motion_detect (
  input  logic                              clk,
  input  logic                              rst_n,
  sdmd_pix_if.sink                          in_px,
  sdmd_res_if.source                        out_res,
  input  logic                              cfg_we,
  input  logic [sdmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [sdmd_pkg::CFG_SIZE_W-1:0] frame_width_r;
  logic [sdmd_pkg::CFG_SIZE_W-1:0] frame_height_r;
  logic [sdmd_pkg::GAIN_W-1:0]     variance_gain_r;

  logic           clearing;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  sdmd_pkg::job_t push_job, pop_job;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= sdmd_pkg::RST_FRAME_WIDTH;
      frame_height_r  <= sdmd_pkg::RST_FRAME_HEIGHT;
      variance_gain_r <= sdmd_pkg::RST_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdmd_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_wdata[sdmd_pkg::CFG_SIZE_W-1:0];
        end
        sdmd_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wdata[sdmd_pkg::CFG_SIZE_W-1:0];
        end
        sdmd_pkg::REG_VARIANCE_GAIN: begin
          variance_gain_r <= cfg_wdata[sdmd_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: hold pixels off during the store sweep, classify the rest by position.
  sdmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_px        (in_px),
    .enable       (!clearing),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_job     (push_job)
  );

  // Queue: absorb a stall on either side without losing a transfer.
  sdmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Back: read the model word, update it, write it back, present the result.
  sdmd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .variance_gain (variance_gain_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_job       (pop_job),
    .clearing      (clearing),
    .out_res       (out_res)
  );

endmodule

### rtl/core/sdmd_front.sv
// Front end: takes pixels, tracks raster position, forms store address and end of frame.
module sdmd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  sdmd_pix_if.sink                            in_px,
  input  logic                                enable,
  input  logic [sdmd_pkg::CFG_SIZE_W-1:0]     frame_width,
  input  logic [sdmd_pkg::CFG_SIZE_W-1:0]     frame_height,
  output logic                                push_valid,
  input  logic                                push_ready,
  output sdmd_pkg::job_t                      push_job
);

  logic [sdmd_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [sdmd_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [sdmd_pkg::W_DIM_W-1:0] w_lim, col_ext;
  logic [sdmd_pkg::H_DIM_W-1:0] h_lim, row_ext;
  logic [sdmd_pkg::COL_W-1:0]   col_c;
  logic [sdmd_pkg::ROW_W-1:0]   row_c;
  logic                         col_wrap, row_wrap, accept;

  assign in_px.ready = enable && push_ready;
  assign push_valid  = enable && in_px.valid;
  assign accept      = in_px.valid && in_px.ready;

  always_comb begin
    w_lim   = sdmd_pkg::limit_width(frame_width);
    h_lim   = sdmd_pkg::limit_height(frame_height);
    col_ext = sdmd_pkg::W_DIM_W'(col_r);
    row_ext = sdmd_pkg::H_DIM_W'(row_r);
    // Clamp a position left beyond a shrunken frame onto its last column or row.
    col_c = (col_ext >= w_lim) ? sdmd_pkg::COL_W'(w_lim - 1'b1) : col_r;
    row_c = (row_ext >= h_lim) ? sdmd_pkg::ROW_W'(h_lim - 1'b1) : row_r;
    col_wrap = (col_ext + sdmd_pkg::W_DIM_W'(1)) >= w_lim;
    row_wrap = (row_ext + sdmd_pkg::H_DIM_W'(1)) >= h_lim;

    col_nxt = col_r;
    row_nxt = row_r;
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end

    push_job.addr  = sdmd_pkg::ADDR_W'(row_c) * sdmd_pkg::ADDR_W'(sdmd_pkg::MAX_WIDTH)
                   + sdmd_pkg::ADDR_W'(col_c);
    push_job.pixel = in_px.pixel;
    push_job.eof   = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### rtl/core/sdmd_queue.sv
// Short FIFO of classified pixels between the front and back ends.
module sdmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sdmd_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sdmd_pkg::job_t pop_job
);

  sdmd_pkg::job_t              slot_r [sdmd_pkg::QDEPTH];
  logic [sdmd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sdmd_pkg::QCNT_W-1:0] cnt_r;
  logic                        do_push, do_pop;

  assign push_ready = cnt_r != sdmd_pkg::QCNT_W'(sdmd_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == sdmd_pkg::QPTR_W'(sdmd_pkg::QDEPTH - 1)) ? '0
                                                                           : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == sdmd_pkg::QPTR_W'(sdmd_pkg::QDEPTH - 1)) ? '0
                                                                           : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### rtl/core/sdmd_back.sv
// Back end: model store, read-update-write pipeline and result register.
module sdmd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sdmd_pkg::GAIN_W-1:0]   variance_gain,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  sdmd_pkg::job_t                pop_job,
  output logic                          clearing,
  sdmd_res_if.source                    out_res
);

  sdmd_pkg::model_word_t       mem [sdmd_pkg::STORE_DEPTH];

  logic                        clr_active_r;
  logic [sdmd_pkg::ADDR_W-1:0] clr_addr_r;

  logic                        s1_valid_r;
  sdmd_pkg::job_t              s1_job_r;
  sdmd_pkg::model_word_t       rdata_r;
  logic                        fwd_hit_r;
  sdmd_pkg::model_word_t       fwd_word_r;

  logic                        out_valid_r;
  logic                        motion_r;
  logic [sdmd_pkg::PIX_W-1:0]  diff_r;
  logic                        eof_r;

  logic                        issue, s2_go, wr_en;
  logic [sdmd_pkg::ADDR_W-1:0] wr_addr;
  sdmd_pkg::model_word_t       wr_word, cur, upd;
  logic [sdmd_pkg::PIX_W-1:0]  bg_new, diff;
  logic [sdmd_pkg::TGT_W-1:0]  target;
  logic [sdmd_pkg::VAR_EXT_W-1:0] var_ext;
  logic                        motion;

  assign clearing  = clr_active_r;
  assign s2_go     = s1_valid_r && (!out_valid_r || out_res.ready);
  assign pop_ready = !clr_active_r && (!s1_valid_r || s2_go);
  assign issue     = pop_valid && pop_ready;

  // Update one position: background and variance each step by at most one; flag motion.
  always_comb begin
    cur = fwd_hit_r ? fwd_word_r : rdata_r;
    if (cur.bg < s1_job_r.pixel) bg_new = cur.bg + 1'b1;
    else if (cur.bg > s1_job_r.pixel) bg_new = cur.bg - 1'b1;
    else bg_new = cur.bg;
    diff = (bg_new > s1_job_r.pixel) ? bg_new - s1_job_r.pixel : s1_job_r.pixel - bg_new;
    target = sdmd_pkg::TGT_W'(diff) * sdmd_pkg::TGT_W'(variance_gain);
    if (sdmd_pkg::TGT_W'(cur.var_est) < target)
      var_ext = sdmd_pkg::VAR_EXT_W'(cur.var_est) + 1'b1;
    else if (sdmd_pkg::TGT_W'(cur.var_est) > target)
      var_ext = sdmd_pkg::VAR_EXT_W'(cur.var_est) - 1'b1;
    else
      var_ext = sdmd_pkg::VAR_EXT_W'(cur.var_est);
    upd.bg = bg_new;
    if (var_ext > sdmd_pkg::VAR_EXT_W'(sdmd_pkg::VAR_MAX)) upd.var_est = sdmd_pkg::VAR_MAX;
    else if (var_ext < sdmd_pkg::VAR_EXT_W'(sdmd_pkg::VAR_MIN)) upd.var_est = sdmd_pkg::VAR_MIN;
    else upd.var_est = var_ext[sdmd_pkg::PIX_W-1:0];
    motion = diff >= upd.var_est;
  end

  // Single write port shared by the clearing pass and the update.
  always_comb begin
    wr_en   = clr_active_r || s2_go;
    wr_addr = clr_active_r ? clr_addr_r : s1_job_r.addr;
    wr_word = clr_active_r ? sdmd_pkg::CLEAR_WORD : upd;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (issue) rdata_r <= mem[pop_job.addr];
  end

  // Capture a write that lands on the address being read in the same cycle.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_job_r   <= pop_job;
      fwd_hit_r  <= s2_go && (s1_job_r.addr == pop_job.addr);
      fwd_word_r <= upd;
    end
    if (s2_go) begin
      motion_r <= motion;
      diff_r   <= diff;
      eof_r    <= s1_job_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == sdmd_pkg::ADDR_W'(sdmd_pkg::STORE_DEPTH - 1)) clr_active_r <= 1'b0;
      end
      if (issue) s1_valid_r <= 1'b1;
      else if (s2_go) s1_valid_r <= 1'b0;
      if (s2_go) out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.motion         = motion_r;
  assign out_res.abs_difference = diff_r;
  assign out_res.end_of_frame   = eof_r;

endmodule

### rtl/core/sdmd_checker.sv
// Port-level checker for the motion detector and its bind to the top level.
`include "assert_macros.svh"

module sdmd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         motion,
  input logic [sdmd_pkg::PIX_W-1:0]   abs_difference,
  input logic                         end_of_frame
);

  // Store sweep runs right after reset: no pixel taken, no result shown.
  `SDMD_ASSERT_NOW(a_quiet_after_reset, !$past(rst_n), !in_ready && !out_valid, "busy after reset")

  // Variance never drops below one, so a zero difference is never motion.
  `SDMD_ASSERT_NOW(a_zero_diff_still, out_valid && abs_difference == '0, !motion, "motion on zero diff")

  // Hold a stalled result until it transfers.
  `SDMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  `SDMD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable(motion) && $stable(abs_difference) && $stable(end_of_frame),
                    "stalled result changed")

endmodule

bind sigma_delta_motion_detect sdmd_checker u_sdmd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_px.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .motion         (out_res.motion),
  .abs_difference (out_res.abs_difference),
  .end_of_frame   (out_res.end_of_frame)
);

### bench/sigma_delta_motion_detect_tb.sv
// Self-checking testbench for the sigma-delta motion detector: random pixel streams, checked per result.
`timescale 1ns / 100ps

module sigma_delta_motion_detect_tb;

  localparam int ITEMS       = 1750;
  localparam int HOLD_CYCLES = 400;
  localparam int END_SLACK   = 16;
  // The store sweep after reset dominates; allow several times the whole run.
  localparam int CYCLE_LIMIT = 4 * sdmd_pkg::STORE_DEPTH;

  // Index past the register list; writes to it must be ignored.
  localparam logic [sdmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {PAT_SCENE, PAT_EXTREME, PAT_UNIFORM, PAT_FLAT} pattern_t;

  typedef struct {
    logic                       motion;
    logic [sdmd_pkg::PIX_W-1:0] abs_difference;
    logic                       end_of_frame;
  } detection_t;

  // Tracks the per-position background/variance model and the expected detections.
  class detection_scoreboard;
    byte unsigned   bg_est[int];
    byte unsigned   var_est[int];
    int             col_pos;
    int             row_pos;
    int             width_reg;
    int             height_reg;
    int             gain_reg;
    detection_t     expected_q[$];
    int             errors;
    int             pixels_in;
    int             checked;
    int             motion_seen;
    int             eof_seen;
    int             saturated_seen;

    function new();
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = sdmd_pkg::RST_FRAME_WIDTH;
      height_reg = sdmd_pkg::RST_FRAME_HEIGHT;
      gain_reg   = sdmd_pkg::RST_GAIN;
    endfunction

    function void write_reg(logic [sdmd_pkg::CFG_IDX_W-1:0] idx,
                            logic [sdmd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sdmd_pkg::REG_FRAME_WIDTH:   width_reg  = data;
        sdmd_pkg::REG_FRAME_HEIGHT:  height_reg = data;
        sdmd_pkg::REG_VARIANCE_GAIN: gain_reg   = data[sdmd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [sdmd_pkg::PIX_W-1:0] pix);
      int w, h, c, r, addr, p, bg, diff, v, target;
      detection_t d;
      p = pix;
      w = (width_reg == 0) ? 1 :
          (width_reg > sdmd_pkg::MAX_WIDTH) ? sdmd_pkg::MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 :
          (height_reg > sdmd_pkg::MAX_HEIGHT) ? sdmd_pkg::MAX_HEIGHT : height_reg;
      // A counter left past a shrunken frame addresses the last column/row.
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      addr = r * sdmd_pkg::MAX_WIDTH + c;

      bg = bg_est.exists(addr) ? bg_est[addr] : sdmd_pkg::BG_CLEAR;
      if (bg < p) bg++;
      else if (bg > p) bg--;
      bg_est[addr] = 8'(bg);
      diff = (bg > p) ? bg - p : p - bg;

      v = var_est.exists(addr) ? var_est[addr] : sdmd_pkg::VAR_MIN;
      target = gain_reg * diff;
      if (v < target) v++;
      else if (v > target) v--;
      if (v > sdmd_pkg::VAR_MAX) begin
        v = sdmd_pkg::VAR_MAX;
        saturated_seen++;
      end
      if (v < sdmd_pkg::VAR_MIN) v = sdmd_pkg::VAR_MIN;
      var_est[addr] = 8'(v);

      d.end_of_frame = 1'b0;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          d.end_of_frame = 1'b1;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
      d.motion = (diff >= v);
      d.abs_difference = sdmd_pkg::PIX_W'(diff);
      expected_q.push_back(d);
      pixels_in++;
    endfunction

    function void check_result(logic motion, logic [sdmd_pkg::PIX_W-1:0] abs_difference,
                               logic end_of_frame);
      detection_t d;
      if (expected_q.size() == 0) begin
        $error("result with no pixel outstanding: motion %0b diff %0d eof %0b",
               motion, abs_difference, end_of_frame);
        errors++;
        return;
      end
      d = expected_q.pop_front();
      checked++;
      if (motion !== d.motion) begin
        $error("motion: expected %0b, got %0b", d.motion, motion);
        errors++;
      end
      if (abs_difference !== d.abs_difference) begin
        $error("abs_difference: expected %0d, got %0d", d.abs_difference, abs_difference);
        errors++;
      end
      if (end_of_frame !== d.end_of_frame) begin
        $error("end_of_frame: expected %0b, got %0b", d.end_of_frame, end_of_frame);
        errors++;
      end
      if (d.motion) motion_seen++;
      if (d.end_of_frame) eof_seen++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [sdmd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sdmd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sdmd_pix_if pix_ch ();
  sdmd_res_if res_ch ();

  sigma_delta_motion_detect dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (pix_ch.sink),
    .out_res   (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  detection_scoreboard sb;

  int           send_idle_pct;
  int           recv_idle_pct;
  bit           long_hold_req;
  int           sent;
  int           reg_writes;
  int           cycles;
  byte unsigned scene[256];
  byte unsigned flat_level;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up if the run hangs; a clean run ends far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sigma_delta_motion_detect_tb: errors");
      $finish;
    end
  end

  // Observe both channels at the edge: a transfer into the block feeds the
  // predictor, a transfer out of it is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && pix_ch.valid && pix_ch.ready) sb.note_pixel(pix_ch.pixel);
    if (rst_n && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.motion, res_ch.abs_difference, res_ch.end_of_frame);
  end

  // Result side: random backpressure, plus one long hold-off on request so the
  // internal queue fills and the block has to stall its input.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // Offer one pixel after a random gap; return at the edge of its transfer.
  task automatic send_pixel(input logic [sdmd_pkg::PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= pix;
    do @(posedge clk); while (!pix_ch.ready);
    sent++;
  endtask

  // Drop valid and hold until every expected detection has come back.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    // Let the last transfer reach the scoreboard before counting what is left.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write one register, then idle with the enable low so each enable edge carries one assignment.
  task automatic write_reg(input logic [sdmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sdmd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // Mostly small frames so positions are revisited often; now and then the
  // edges: zero, exactly the maximum, and above the maximum.
  function automatic logic [sdmd_pkg::CFG_SIZE_W-1:0] pick_size(input int small_max);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return sdmd_pkg::CFG_SIZE_W'($urandom_range(1, small_max));
    if (sel < 80) return sdmd_pkg::CFG_SIZE_W'($urandom_range(small_max + 1, 64));
    if (sel < 88) return sdmd_pkg::CFG_SIZE_W'($urandom_range(65, 1024));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return sdmd_pkg::CFG_SIZE_W'(sdmd_pkg::MAX_WIDTH);
      2:       return '1;
      default: return sdmd_pkg::CFG_SIZE_W'($urandom_range(1025, 2047));
    endcase
  endfunction

  function automatic logic [sdmd_pkg::PIX_W-1:0] next_pixel(input pattern_t pat,
                                                            input int k);
    int v;
    case (pat)
      PAT_SCENE: begin
        // Steady scene with sensor noise; an occasional jump stands in for motion.
        if ($urandom_range(0, 99) < 6) return sdmd_pkg::PIX_W'($urandom_range(0, 255));
        v = scene[(sb.row_pos * 7 + sb.col_pos) % 256] + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return sdmd_pkg::PIX_W'(v);
      end
      PAT_EXTREME: return (k % 2 == 0) ? 8'd255 : 8'd0;
      PAT_FLAT:    return flat_level;
      default:     return sdmd_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_segment(input pattern_t pat, input int count);
    foreach (scene[i]) scene[i] = 8'($urandom_range(0, 255));
    flat_level = 8'($urandom_range(0, 255));
    for (int k = 0; k < count; k++) send_pixel(next_pixel(pat, k));
  endtask

  // Short hand-picked opening: pixel extremes, degenerate and oversized frames,
  // gain zero, a frame shrunk under the position counters, an ignored index.
  task automatic run_directed();
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    send_pixel(8'd1);
    drain();
    // Zero sizes collapse to a single position; gain zero pulls the variance to 1.
    write_reg(sdmd_pkg::REG_FRAME_WIDTH, '0);
    write_reg(sdmd_pkg::REG_FRAME_HEIGHT, '0);
    write_reg(sdmd_pkg::REG_VARIANCE_GAIN, '0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    drain();
    // Sizes above the maximum saturate to the full frame.
    write_reg(sdmd_pkg::REG_FRAME_WIDTH, '1);
    write_reg(sdmd_pkg::REG_FRAME_HEIGHT, sdmd_pkg::CFG_SIZE_W'(1025));
    write_reg(sdmd_pkg::REG_VARIANCE_GAIN, sdmd_pkg::CFG_DATA_W'(15));
    send_pixel(8'd170);
    send_pixel(8'd85);
    drain();
    // Run to the end of a row, then narrow the row to three columns.
    write_reg(sdmd_pkg::REG_FRAME_WIDTH, sdmd_pkg::CFG_DATA_W'(8));
    write_reg(sdmd_pkg::REG_FRAME_HEIGHT, sdmd_pkg::CFG_DATA_W'(2));
    write_reg(sdmd_pkg::REG_VARIANCE_GAIN, sdmd_pkg::CFG_DATA_W'(7));
    for (int k = 0; k < 6; k++) send_pixel(8'(k * 40 + 15));
    drain();
    write_reg(sdmd_pkg::REG_FRAME_WIDTH, sdmd_pkg::CFG_DATA_W'(3));
    send_pixel(8'd200);
    send_pixel(8'd0);
    drain();
    // Shrink the frame height under the row counter.
    write_reg(sdmd_pkg::REG_FRAME_HEIGHT, sdmd_pkg::CFG_DATA_W'(1));
    write_reg(REG_UNUSED, '1);
    send_pixel(8'd99);
    send_pixel(8'd254);
    drain();
  endtask

  initial begin
    int       count;
    pattern_t pat;
    bit       hold_done;

    sb = new();
    cycles        = 0;
    sent          = 0;
    reg_writes    = 0;
    long_hold_req = 1'b0;
    hold_done     = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 82;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Input ready stays low through the store sweep; the first transfer waits it out.
    run_directed();

    // One position, maximum gain, alternating extremes: the variance steps by
    // one per pixel toward gain times the difference.
    write_reg(sdmd_pkg::REG_FRAME_WIDTH, sdmd_pkg::CFG_DATA_W'(1));
    write_reg(sdmd_pkg::REG_FRAME_HEIGHT, sdmd_pkg::CFG_DATA_W'(1));
    write_reg(sdmd_pkg::REG_VARIANCE_GAIN, sdmd_pkg::CFG_DATA_W'(15));
    run_segment(PAT_EXTREME, 300);
    drain();

    while (sent < ITEMS) begin
      // Advance the idling schedule: sender-light, then receiver-light, then none.
      if (sent < ITEMS / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 82;
      end else if (sent < 2 * ITEMS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if ($urandom_range(0, 99) < 80) write_reg(sdmd_pkg::REG_FRAME_WIDTH, pick_size(12));
      if ($urandom_range(0, 99) < 70) write_reg(sdmd_pkg::REG_FRAME_HEIGHT, pick_size(6));
      if ($urandom_range(0, 99) < 70) begin
        // Upper data bits do not belong to the gain; set them at random.
        write_reg(sdmd_pkg::REG_VARIANCE_GAIN,
                  {sdmd_pkg::CFG_DATA_W'($urandom_range(0, 127)) << sdmd_pkg::GAIN_W} |
                  sdmd_pkg::CFG_DATA_W'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 99) < 10)
        write_reg(REG_UNUSED, sdmd_pkg::CFG_DATA_W'($urandom_range(0, 2047)));

      case ($urandom_range(0, 99)) inside
        [0:49]:  pat = PAT_SCENE;
        [50:64]: pat = PAT_EXTREME;
        [65:84]: pat = PAT_UNIFORM;
        default: pat = PAT_FLAT;
      endcase
      count = $urandom_range(20, 90);

      // Once there is no idling, hold the result side off for a long stretch
      // while the sender keeps offering pixels.
      if (send_idle_pct == 0 && !hold_done) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
        count         = 90;
      end
      run_segment(pat, count);
      drain();
    end

    repeat (END_SLACK) @(posedge clk);
    $display("covered %0d pixels, %0d detections checked (%0d motion, %0d frame ends)",
             sb.pixels_in, sb.checked, sb.motion_seen, sb.eof_seen);
    $display("%0d register writes, %0d variance saturations", reg_writes, sb.saturated_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sigma_delta_motion_detect_tb: clean");
    end else begin
      $display("sigma_delta_motion_detect_tb: errors");
    end
    $finish;
  end

endmodule
